// ===== rtl/tcx_pkg.sv =====
// tcx_pkg: shared codes and types for the triangle clipper against x <= w
// no dependencies
`timescale 1ns / 1ps

package tcx_pkg;

    // how the input triangle sits against the plane
    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_ALL  = 2'd1,
        MODE_ONE  = 2'd2,
        MODE_TWO  = 2'd3
    } mode_t;

    localparam int NUM_CORNERS = 3;
    localparam int NUM_COORDS  = 4;
    localparam int COORD_X     = 0;
    localparam int COORD_W     = 3;

    localparam logic [2:0] LAST_IDX_ONE_TRI = 3'd2;
    localparam logic [2:0] LAST_IDX_TWO_TRI = 3'd5;

    // hand-off from the lane pipeline to the output merge stage
    typedef struct packed {
        logic  load;
        mode_t mode;
    } tcx_load_t;

endpackage

// ===== rtl/tcx_tri_if.sv =====
// tcx_tri_if: input triangle channel, three homogeneous vertices per item
// no dependencies
`timescale 1ns / 1ps

interface tcx_tri_if #(
    parameter int CW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v0_w;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v1_w;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    logic signed [CW-1:0] v2_w;

    modport source (
        output valid, v0_x, v0_y, v0_z, v0_w, v1_x, v1_y, v1_z, v1_w,
               v2_x, v2_y, v2_z, v2_w,
        input  ready
    );
    modport sink (
        input  valid, v0_x, v0_y, v0_z, v0_w, v1_x, v1_y, v1_z, v1_w,
               v2_x, v2_y, v2_z, v2_w,
        output ready
    );
endinterface

// ===== rtl/tcx_vtx_if.sv =====
// tcx_vtx_if: output vertex channel, one clipped vertex per item
// no dependencies
`timescale 1ns / 1ps

interface tcx_vtx_if #(
    parameter int CW = 32
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic signed [CW-1:0] out_w;
    logic [1:0]           corner;
    logic                 last;

    modport source (
        output valid, out_x, out_y, out_z, out_w, corner, last,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_w, corner, last,
        output ready
    );
endinterface

// ===== rtl/tcx_lane.sv =====
// tcx_lane: one edge crossing unit, pipelined restoring divide for t,
// then scale of the edge delta and add; depends on tcx_pkg
`timescale 1ns / 1ps

module tcx_lane #(
    parameter int CE = 32,
    parameter int FB = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CE-1:0] s_c [tcx_pkg::NUM_COORDS],
    input  logic signed [CE-1:0] e_c [tcx_pkg::NUM_COORDS],
    output logic signed [CE-1:0] x_c [tcx_pkg::NUM_COORDS]
);
    import tcx_pkg::*;

    localparam logic signed [CE+1:0] SAT_HI = (CE+2)'((64'sd1 <<< (CE-1)) - 64'sd1);
    localparam logic signed [CE+1:0] SAT_LO = -SAT_HI - (CE+2)'(1);

    logic signed [CE:0] ds;
    logic signed [CE:0] de;
    logic [CE:0]        num;
    logic [CE+1:0]      den;

    logic [CE+1:0]        rem_reg [FB+1];
    logic [CE+1:0]        den_reg [FB+1];
    logic [FB-1:0]        t_reg   [FB+1];
    logic signed [CE-1:0] s_reg   [FB+1][NUM_COORDS];
    logic signed [CE-1:0] e_reg   [FB+1][NUM_COORDS];

    logic [CE:0]          q_reg   [NUM_COORDS];
    logic                 neg_reg [NUM_COORDS];
    logic signed [CE-1:0] sm_reg  [NUM_COORDS];
    logic signed [CE-1:0] x_reg   [NUM_COORDS];

    assign ds  = (CE+1)'(s_c[COORD_X]) - (CE+1)'(s_c[COORD_W]);
    assign de  = (CE+1)'(e_c[COORD_X]) - (CE+1)'(e_c[COORD_W]);
    assign num = (CE+1)'(-ds);
    assign den = {1'b0, de} + {1'b0, num};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, num};
            den_reg[0] <= den;
            t_reg[0]   <= '0;
            s_reg[0]   <= s_c;
            e_reg[0]   <= e_c;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= FB; k++)
    begin : g_div
        logic [CE+2:0] r2;
        logic          ge;
        logic [CE+2:0] diff;

        assign r2   = {rem_reg[k-1], 1'b0};
        assign ge   = r2 >= {1'b0, den_reg[k-1]};
        assign diff = r2 - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[CE+1:0] : r2[CE+1:0];
                den_reg[k] <= den_reg[k-1];
                t_reg[k]   <= {t_reg[k-1][FB-2:0], ge};
                s_reg[k]   <= s_reg[k-1];
                e_reg[k]   <= e_reg[k-1];
            end
        end
    end

    for (genvar c = 0; c < NUM_COORDS; c++)
    begin : g_coord
        logic signed [CE:0]    delta;
        logic [CE:0]           mag;
        logic [FB+CE:0]        prod;
        logic signed [CE+1:0]  sum;

        assign delta = (CE+1)'(e_reg[FB][c]) - (CE+1)'(s_reg[FB][c]);
        assign mag   = delta[CE] ? (CE+1)'(-delta) : delta;
        assign prod  = (FB+CE+1)'(t_reg[FB]) * (FB+CE+1)'(mag);
        assign sum   = neg_reg[c] ? (CE+2)'(sm_reg[c]) - signed'({1'b0, q_reg[c]})
                                  : (CE+2)'(sm_reg[c]) + signed'({1'b0, q_reg[c]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[c]   <= prod[FB+CE:FB];
                neg_reg[c] <= delta[CE];
                sm_reg[c]  <= s_reg[FB][c];
                if (sum > SAT_HI)
                    x_reg[c] <= SAT_HI[CE-1:0];
                else if (sum < SAT_LO)
                    x_reg[c] <= SAT_LO[CE-1:0];
                else
                    x_reg[c] <= sum[CE-1:0];
            end
        end
    end

    assign x_c = x_reg;

endmodule

// ===== rtl/tcx_merge.sv =====
// tcx_merge: holds one clipped triangle set and sends its vertices in order
// depends on tcx_pkg and tcx_vtx_if
`timescale 1ns / 1ps

module tcx_merge #(
    parameter int CW = 32,
    parameter int CE = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcx_pkg::tcx_load_t    ld,
    output logic                  take,
    input  logic signed [CE-1:0]  p0 [tcx_pkg::NUM_COORDS],
    input  logic signed [CE-1:0]  p1 [tcx_pkg::NUM_COORDS],
    input  logic signed [CE-1:0]  p2 [tcx_pkg::NUM_COORDS],
    input  logic signed [CE-1:0]  x0 [tcx_pkg::NUM_COORDS],
    input  logic signed [CE-1:0]  x1 [tcx_pkg::NUM_COORDS],
    tcx_vtx_if.source             vtx_out
);
    import tcx_pkg::*;

    logic                 busy_reg;
    logic [2:0]           idx_reg;
    mode_t                mode_reg;
    logic signed [CE-1:0] p0_reg [NUM_COORDS];
    logic signed [CE-1:0] p1_reg [NUM_COORDS];
    logic signed [CE-1:0] p2_reg [NUM_COORDS];
    logic signed [CE-1:0] x0_reg [NUM_COORDS];
    logic signed [CE-1:0] x1_reg [NUM_COORDS];

    logic                 is_last;
    logic                 fire;
    logic signed [CE-1:0] sel [NUM_COORDS];

    assign is_last = (mode_reg == MODE_TWO) ? (idx_reg == LAST_IDX_TWO_TRI)
                                            : (idx_reg == LAST_IDX_ONE_TRI);
    assign fire    = busy_reg && vtx_out.ready;
    assign take    = !busy_reg || (vtx_out.ready && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            mode_reg <= MODE_NONE;
        end
        else if (ld.load && take)
        begin
            busy_reg <= (ld.mode != MODE_NONE);
            idx_reg  <= '0;
            mode_reg <= ld.mode;
        end
        else if (fire)
        begin
            if (is_last)
                busy_reg <= 1'b0;
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load && take)
        begin
            p0_reg <= p0;
            p1_reg <= p1;
            p2_reg <= p2;
            x0_reg <= x0;
            x1_reg <= x1;
        end
    end

    // vertex order per case
    always_comb
    begin
        sel = p0_reg;
        unique case (mode_reg)
            MODE_ALL:
            begin
                if (idx_reg == 3'd1)
                    sel = p1_reg;
                else if (idx_reg == 3'd2)
                    sel = p2_reg;
            end
            MODE_ONE:
            begin
                if (idx_reg == 3'd1)
                    sel = x0_reg;
                else if (idx_reg == 3'd2)
                    sel = x1_reg;
            end
            MODE_TWO:
            begin
                if (idx_reg == 3'd1 || idx_reg == 3'd3)
                    sel = p1_reg;
                else if (idx_reg == 3'd2 || idx_reg == 3'd5)
                    sel = x0_reg;
                else if (idx_reg == 3'd4)
                    sel = x1_reg;
            end
            default:
            begin
                sel = p0_reg;
            end
        endcase
    end

    assign vtx_out.valid  = busy_reg;
    assign vtx_out.out_x  = CW'(sel[0]);
    assign vtx_out.out_y  = CW'(sel[1]);
    assign vtx_out.out_z  = CW'(sel[2]);
    assign vtx_out.out_w  = CW'(sel[3]);
    assign vtx_out.corner = (idx_reg >= 3'd3) ? 2'(idx_reg - 3'd3) : idx_reg[1:0];
    assign vtx_out.last   = is_last;

endmodule

// ===== rtl/triangle_clip_max_x_plane.sv =====
// Clips a homogeneous triangle against the plane x <= w.
//
// Channels: tri_in (sink) takes one triangle per item, v0..v2 each with
// x, y, z, w in signed fixed point. vtx_out (source) gives the clipped
// result as runs of 0, 3 or 6 vertices; corner counts 0..2 inside each
// output triangle and last marks the final vertex of an input triangle.
// A triangle fully outside produces no output items.
// Two crossing lanes run side by side behind an input register, each a
// FRAC_BITS-stage divide pipeline for t, one multiply stage and one
// add/saturate stage. A new triangle may enter every cycle while
// tri_in.ready is high; the vertex port sends one vertex per cycle while
// vtx_out.ready is high, so the sustained rate is set by the output.
// Reset clears all valid flags; no item is in flight after reset.
// When vtx_out stalls, the merge stage holds its vertex; the lane pipeline
// freezes, dropping tri_in.ready, while its last stage is full and untaken.
// depends on tcx_pkg, tcx_tri_if, tcx_vtx_if, tcx_lane, tcx_merge
`timescale 1ns / 1ps

module triangle_clip_max_x_plane #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    tcx_tri_if.sink    tri_in,
    tcx_vtx_if.source  vtx_out
);
    import tcx_pkg::*;

    localparam int CE = (COORD_WIDTH > 62) ? 62 : COORD_WIDTH;
    localparam int L  = FRAC_BITS + 3;

    logic signed [CE-1:0] v [NUM_CORNERS][NUM_COORDS];
    logic signed [CE:0]   d [NUM_CORNERS];
    logic [2:0]           ins;
    mode_t                mode;
    logic [1:0]           ia, ib, ie0, ie1;

    logic signed [CE-1:0] l0_s [NUM_COORDS];
    logic signed [CE-1:0] l0_e [NUM_COORDS];
    logic signed [CE-1:0] l1_s [NUM_COORDS];
    logic signed [CE-1:0] l1_e [NUM_COORDS];
    logic signed [CE-1:0] x0   [NUM_COORDS];
    logic signed [CE-1:0] x1   [NUM_COORDS];

    logic                 pv_reg   [L];
    mode_t                mode_reg [L];
    logic signed [CE-1:0] pp_reg   [L][NUM_CORNERS][NUM_COORDS];

    logic      en;
    logic      take;
    tcx_load_t ld;

    assign v[0][0] = tri_in.v0_x[CE-1:0];
    assign v[0][1] = tri_in.v0_y[CE-1:0];
    assign v[0][2] = tri_in.v0_z[CE-1:0];
    assign v[0][3] = tri_in.v0_w[CE-1:0];
    assign v[1][0] = tri_in.v1_x[CE-1:0];
    assign v[1][1] = tri_in.v1_y[CE-1:0];
    assign v[1][2] = tri_in.v1_z[CE-1:0];
    assign v[1][3] = tri_in.v1_w[CE-1:0];
    assign v[2][0] = tri_in.v2_x[CE-1:0];
    assign v[2][1] = tri_in.v2_y[CE-1:0];
    assign v[2][2] = tri_in.v2_z[CE-1:0];
    assign v[2][3] = tri_in.v2_w[CE-1:0];

    for (genvar i = 0; i < NUM_CORNERS; i++)
    begin : g_dist
        assign d[i]   = (CE+1)'(v[i][COORD_X]) - (CE+1)'(v[i][COORD_W]);
        assign ins[i] = d[i][CE] || (d[i] == '0);
    end

    // pick the case and the vertex feeding each lane
    always_comb
    begin
        mode = MODE_NONE;
        ia   = 2'd0;
        ib   = 2'd1;
        ie0  = 2'd2;
        ie1  = 2'd2;
        unique case (ins)
            3'b111:
            begin
                mode = MODE_ALL;
            end
            3'b001, 3'b010, 3'b100:
            begin
                mode = MODE_ONE;
                ia   = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
                ib   = ia;
                ie0  = (ia == 2'd0) ? 2'd1 : 2'd0;
                ie1  = (ia == 2'd2) ? 2'd1 : 2'd2;
            end
            3'b011, 3'b101, 3'b110:
            begin
                mode = MODE_TWO;
                ie0  = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);
                ie1  = ie0;
                ia   = (ie0 == 2'd0) ? 2'd1 : 2'd0;
                ib   = (ie0 == 2'd2) ? 2'd1 : 2'd2;
            end
            default:
            begin
                mode = MODE_NONE;
            end
        endcase
    end

    // lane 1 starts from b in the two-inside case, from a otherwise
    assign l0_s = v[ia];
    assign l0_e = v[ie0];
    assign l1_s = v[(mode == MODE_TWO) ? ib : ia];
    assign l1_e = v[ie1];

    assign en           = !pv_reg[L-1] || take;
    assign tri_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < L; s++)
                pv_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            pv_reg[0] <= tri_in.valid;
            for (int s = 1; s < L; s++)
                pv_reg[s] <= pv_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg[0]  <= mode;
            pp_reg[0][0] <= v[(mode == MODE_ALL) ? 2'd0 : ia];
            pp_reg[0][1] <= v[(mode == MODE_ALL) ? 2'd1 : ib];
            pp_reg[0][2] <= v[2];
            for (int s = 1; s < L; s++)
            begin
                mode_reg[s] <= mode_reg[s-1];
                pp_reg[s]   <= pp_reg[s-1];
            end
        end
    end

    tcx_lane #(.CE(CE), .FB(FRAC_BITS)) u_lane0 (
        .clk (clk),
        .en  (en),
        .s_c (l0_s),
        .e_c (l0_e),
        .x_c (x0)
    );

    tcx_lane #(.CE(CE), .FB(FRAC_BITS)) u_lane1 (
        .clk (clk),
        .en  (en),
        .s_c (l1_s),
        .e_c (l1_e),
        .x_c (x1)
    );

    assign ld.load = pv_reg[L-1];
    assign ld.mode = mode_reg[L-1];

    tcx_merge #(.CW(COORD_WIDTH), .CE(CE)) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ld      (ld),
        .take    (take),
        .p0      (pp_reg[L-1][0]),
        .p1      (pp_reg[L-1][1]),
        .p2      (pp_reg[L-1][2]),
        .x0      (x0),
        .x1      (x1),
        .vtx_out (vtx_out)
    );

endmodule
